[hw/rtl/panel_menu_walk_sequencer_core_macros.svh]
// assertion macros for the panel menu walk sequencer
// used by the top level only; expects clk and rst_n in scope
`ifndef PANEL_MENU_WALK_SEQUENCER_CORE_MACROS_SVH
`define PANEL_MENU_WALK_SEQUENCER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PMWS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pmws assertion failed");
`define PMWS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pmws assertion failed");
`else
`define PMWS_ASSERT_IMP(lbl, ante, cons)
`define PMWS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/pmws_pkg.sv]
// shared types and constants for the panel menu walk sequencer
// no dependencies
package pmws_pkg;

  localparam logic [7:0] KEY_DWELL       = 8'h00;
  localparam logic [7:0] KEY_MENU_BACK   = 8'h02;
  localparam logic [7:0] KEY_BUTTON_BASE = 8'h11;
  localparam logic [7:0] KEY_BLIND_MENU  = 8'h19;
  localparam logic [7:0] KEY_SUBMIT      = 8'h80;

  localparam logic [7:0] PAGE_HOME  = 8'h01;
  localparam logic [7:0] PAGE_MENU  = 8'h0f;
  localparam logic [7:0] PAGE_CHLOR = 8'h30;

  localparam logic [2:0] PH_NAVIGATE = 3'd0;
  localparam logic [2:0] PH_SELECT   = 3'd1;
  localparam logic [2:0] PH_SUBMIT   = 3'd2;
  localparam logic [2:0] PH_RETURN   = 3'd3;
  localparam logic [2:0] PH_DONE     = 3'd4;
  localparam logic [2:0] PH_FAILED   = 3'd5;

  localparam logic [1:0] ARM_ACCEPTED  = 2'd0;
  localparam logic [1:0] ARM_NOT_SUPP  = 2'd1;
  localparam logic [1:0] ARM_MAP_FAIL  = 2'd2;
  localparam logic [1:0] ARM_INVALID   = 2'd3;

  localparam logic [1:0] CFG_SETTLE    = 2'd0;
  localparam logic [1:0] CFG_UNWIND    = 2'd1;
  localparam logic [1:0] CFG_POLL_LIM  = 2'd2;
  localparam logic [1:0] CFG_MENU_ATT  = 2'd3;

  localparam logic [3:0] SETTLE_RST   = 4'd4;
  localparam logic [3:0] UNWIND_RST   = 4'd6;
  localparam logic [7:0] POLL_LIM_RST = 8'd200;
  localparam logic [2:0] MENU_ATT_RST = 3'd2;

  typedef struct packed {
    logic [3:0] settle_polls;
    logic [3:0] max_unwind;
    logic [7:0] poll_limit;
    logic [2:0] max_menu_attempts;
  } cfg_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] page_id;
    logic       buttons_present;
    logic [6:0] menu_entry_index;
    logic [6:0] pool_row_index;
    logic [6:0] spa_row_index;
    logic [6:0] boost_row_index;
    logic [7:0] target_percent;
    logic [1:0] water_body;
    logic       boost_goal;
    logic       emulation_on;
    logic       channel_in_use;
  } item_t;

  typedef struct packed {
    logic [1:0] arm_status;
    logic       command_issued;
    logic [7:0] command_byte;
    logic       value_armed;
    logic [6:0] armed_percent;
    logic       goal_finished;
    logic       goal_ok;
    logic       route_missing;
  } result_t;

  typedef struct packed {
    logic       goal_pending;
    logic [2:0] phase;
    logic [8:0] poll_cnt;
    logic [3:0] settle_cnt;
    logic [4:0] unwind_cnt;
    logic [3:0] menu_att_cnt;
    logic       route_unavail;
    logic       menu_known;
    logic [5:0] menu_saved;
    logic [6:0] goal_pct;
    logic       goal_spa;
    logic       goal_boost;
  } state_t;

endpackage

[hw/rtl/pmws_step.sv]
// next-state and result logic for one transaction of the menu walk
// depends on pmws_pkg
module pmws_step #(
  parameter int BUTTON_INDEX_LIMIT = 64
) (
  input  pmws_pkg::state_t  st_i,
  input  pmws_pkg::cfg_t    cfg_i,
  input  pmws_pkg::item_t   item_i,
  output pmws_pkg::state_t  st_o,
  output pmws_pkg::result_t res_o
);

  localparam logic [7:0] LIM = 8'(BUTTON_INDEX_LIMIT);

  always_comb begin
    pmws_pkg::state_t  ns;
    pmws_pkg::result_t r;
    logic              known;
    logic [5:0]        saved;
    logic [6:0]        idx;
    logic              do_finish;
    logic              fin_ok;
    logic              do_send;
    logic              do_settle;
    logic [7:0]        key;

    ns        = st_i;
    r         = '0;
    known     = st_i.menu_known;
    saved     = st_i.menu_saved;
    idx       = item_i.pool_row_index;
    do_finish = 1'b0;
    fin_ok    = 1'b0;
    do_send   = 1'b0;
    do_settle = 1'b0;
    key       = pmws_pkg::KEY_DWELL;

    if (!item_i.req_type) begin
      if (!item_i.boost_goal &&
          (item_i.target_percent > 8'd100 || item_i.water_body > 2'd1)) begin
        r.arm_status = pmws_pkg::ARM_INVALID;
      end else if (!item_i.emulation_on) begin
        r.arm_status = pmws_pkg::ARM_NOT_SUPP;
      end else if (st_i.goal_pending || item_i.channel_in_use) begin
        r.arm_status = pmws_pkg::ARM_NOT_SUPP;
      end else if (st_i.route_unavail) begin
        r.arm_status = pmws_pkg::ARM_MAP_FAIL;
      end else begin
        r.arm_status    = pmws_pkg::ARM_ACCEPTED;
        ns.goal_pending = 1'b1;
        ns.goal_boost   = item_i.boost_goal;
        ns.goal_spa     = item_i.boost_goal ? 1'b0 : item_i.water_body[0];
        ns.goal_pct     = item_i.boost_goal ? 7'd0 : item_i.target_percent[6:0];
        ns.phase        = pmws_pkg::PH_NAVIGATE;
        ns.poll_cnt     = '0;
        ns.settle_cnt   = '0;
        ns.unwind_cnt   = '0;
        ns.menu_att_cnt = '0;
      end
    end else if (st_i.goal_pending) begin
      if (st_i.poll_cnt != 9'd511) ns.poll_cnt = st_i.poll_cnt + 9'd1;
      if (st_i.poll_cnt > {1'b0, cfg_i.poll_limit}) begin
        do_finish = 1'b1;
      end else if (st_i.settle_cnt != 4'd0) begin
        ns.settle_cnt = st_i.settle_cnt - 4'd1;
        do_send       = 1'b1;
      end else begin
        case (st_i.phase)
          pmws_pkg::PH_NAVIGATE: begin
            if (item_i.page_id == pmws_pkg::PAGE_CHLOR) begin
              ns.phase      = pmws_pkg::PH_SELECT;
              ns.unwind_cnt = '0;
            end else if (item_i.page_id == pmws_pkg::PAGE_MENU) begin
              if (item_i.buttons_present) begin
                if ({1'b0, item_i.menu_entry_index} < LIM) begin
                  known            = 1'b1;
                  saved            = item_i.menu_entry_index[5:0];
                  ns.route_unavail = 1'b0;
                end else begin
                  known = 1'b0;
                end
              end
              ns.menu_known = known;
              ns.menu_saved = saved;
              if (st_i.menu_att_cnt != 4'd15) ns.menu_att_cnt = st_i.menu_att_cnt + 4'd1;
              if (st_i.menu_att_cnt >= {1'b0, cfg_i.max_menu_attempts}) begin
                ns.route_unavail = 1'b1;
                ns.phase         = pmws_pkg::PH_FAILED;
              end else begin
                do_settle = 1'b1;
                key = known ? (pmws_pkg::KEY_BUTTON_BASE + {2'b00, saved})
                            : pmws_pkg::KEY_BLIND_MENU;
              end
            end else begin
              if (st_i.unwind_cnt != 5'd31) ns.unwind_cnt = st_i.unwind_cnt + 5'd1;
              if (st_i.unwind_cnt >= {1'b0, cfg_i.max_unwind}) begin
                ns.phase = pmws_pkg::PH_FAILED;
              end else begin
                do_settle = 1'b1;
                key       = pmws_pkg::KEY_MENU_BACK;
              end
            end
          end
          pmws_pkg::PH_SELECT: begin
            if (st_i.goal_boost)    idx = item_i.boost_row_index;
            else if (st_i.goal_spa) idx = item_i.spa_row_index;
            if (item_i.page_id != pmws_pkg::PAGE_CHLOR) begin
              ns.phase = pmws_pkg::PH_NAVIGATE;
            end else if (!item_i.buttons_present) begin
              do_send = 1'b1;
            end else if ({1'b0, idx} >= LIM) begin
              ns.phase = pmws_pkg::PH_FAILED;
            end else begin
              do_settle = 1'b1;
              key       = pmws_pkg::KEY_BUTTON_BASE + {1'b0, idx};
              ns.phase  = st_i.goal_boost ? pmws_pkg::PH_RETURN : pmws_pkg::PH_SUBMIT;
            end
          end
          pmws_pkg::PH_SUBMIT: begin
            if (item_i.page_id != pmws_pkg::PAGE_CHLOR) begin
              ns.phase = pmws_pkg::PH_NAVIGATE;
            end else begin
              r.value_armed   = 1'b1;
              r.armed_percent = st_i.goal_pct;
              do_settle       = 1'b1;
              key             = pmws_pkg::KEY_SUBMIT;
              ns.phase        = pmws_pkg::PH_RETURN;
            end
          end
          pmws_pkg::PH_RETURN: begin
            if (item_i.page_id == pmws_pkg::PAGE_HOME) begin
              do_finish = 1'b1;
              fin_ok    = 1'b1;
            end else begin
              if (st_i.unwind_cnt != 5'd31) ns.unwind_cnt = st_i.unwind_cnt + 5'd1;
              if (st_i.unwind_cnt >= {1'b0, cfg_i.max_unwind}) begin
                do_finish = 1'b1;
                fin_ok    = 1'b1;
              end else begin
                do_settle = 1'b1;
                key       = pmws_pkg::KEY_MENU_BACK;
              end
            end
          end
          pmws_pkg::PH_DONE: begin
            do_finish = 1'b1;
            fin_ok    = 1'b1;
          end
          default: begin
            do_finish = 1'b1;
          end
        endcase
      end
    end

    if (do_settle) begin
      r.command_issued = 1'b1;
      r.command_byte   = key;
      ns.settle_cnt    = cfg_i.settle_polls;
    end else if (do_send) begin
      r.command_issued = 1'b1;
      r.command_byte   = pmws_pkg::KEY_DWELL;
    end else if (do_finish) begin
      r.command_issued = 1'b1;
      r.command_byte   = pmws_pkg::KEY_DWELL;
      r.goal_finished  = 1'b1;
      r.goal_ok        = fin_ok;
      ns.goal_pending  = 1'b0;
      // a finish out of return home parks the walk in done
      ns.phase         = (fin_ok && st_i.phase == pmws_pkg::PH_RETURN) ?
                         pmws_pkg::PH_DONE : pmws_pkg::PH_NAVIGATE;
      ns.settle_cnt    = '0;
      ns.unwind_cnt    = '0;
      ns.menu_att_cnt  = '0;
    end

    r.route_missing = ns.route_unavail;
    st_o  = ns;
    res_o = r;
  end

endmodule

[hw/rtl/panel_menu_walk_sequencer_core.sv]
// out_valid rises once an accepted transaction has passed through the input register
// and then the result register; one transaction per cycle while the output is not stalled
// input is taken while a finished result waits only if the input register is empty
// synchronous active-low reset clears walk state, handshake state and config to defaults
// top level of the panel menu walk sequencer; depends on pmws_pkg, pmws_step
// and panel_menu_walk_sequencer_core_macros.svh
`include "panel_menu_walk_sequencer_core_macros.svh"
module panel_menu_walk_sequencer_core #(
  parameter int BUTTON_INDEX_LIMIT = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_req_type,
  input  logic [7:0] in_page_id,
  input  logic       in_buttons_present,
  input  logic [6:0] in_menu_entry_index,
  input  logic [6:0] in_pool_row_index,
  input  logic [6:0] in_spa_row_index,
  input  logic [6:0] in_boost_row_index,
  input  logic [7:0] in_target_percent,
  input  logic [1:0] in_water_body,
  input  logic       in_boost_goal,
  input  logic       in_emulation_on,
  input  logic       in_channel_in_use,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_arm_status,
  output logic       out_command_issued,
  output logic [7:0] out_command_byte,
  output logic       out_value_armed,
  output logic [6:0] out_armed_percent,
  output logic       out_goal_finished,
  output logic       out_goal_ok,
  output logic       out_route_missing
);

  pmws_pkg::cfg_t    cfg_r;
  pmws_pkg::state_t  st_r;
  pmws_pkg::state_t  st_nxt;
  pmws_pkg::item_t   item_r;
  pmws_pkg::result_t res_r;
  pmws_pkg::result_t res_nxt;
  logic              item_valid_r;
  logic              out_valid_r;
  logic              item_adv;
  logic              in_acc;

  assign item_adv = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !item_valid_r || item_adv;
  assign in_acc   = in_valid && in_ready;

  pmws_step #(
    .BUTTON_INDEX_LIMIT(BUTTON_INDEX_LIMIT)
  ) u_step (
    .st_i   (st_r),
    .cfg_i  (cfg_r),
    .item_i (item_r),
    .st_o   (st_nxt),
    .res_o  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_polls      <= pmws_pkg::SETTLE_RST;
      cfg_r.max_unwind        <= pmws_pkg::UNWIND_RST;
      cfg_r.poll_limit        <= pmws_pkg::POLL_LIM_RST;
      cfg_r.max_menu_attempts <= pmws_pkg::MENU_ATT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pmws_pkg::CFG_SETTLE:   cfg_r.settle_polls      <= cfg_wdata[3:0];
        pmws_pkg::CFG_UNWIND:   cfg_r.max_unwind        <= cfg_wdata[3:0];
        pmws_pkg::CFG_POLL_LIM: cfg_r.poll_limit        <= cfg_wdata;
        pmws_pkg::CFG_MENU_ATT: cfg_r.max_menu_attempts <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= '0;
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (item_adv) st_r <= st_nxt;
      if (in_acc)        item_valid_r <= 1'b1;
      else if (item_adv) item_valid_r <= 1'b0;
      if (item_adv)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.req_type         <= in_req_type;
      item_r.page_id          <= in_page_id;
      item_r.buttons_present  <= in_buttons_present;
      item_r.menu_entry_index <= in_menu_entry_index;
      item_r.pool_row_index   <= in_pool_row_index;
      item_r.spa_row_index    <= in_spa_row_index;
      item_r.boost_row_index  <= in_boost_row_index;
      item_r.target_percent   <= in_target_percent;
      item_r.water_body       <= in_water_body;
      item_r.boost_goal       <= in_boost_goal;
      item_r.emulation_on     <= in_emulation_on;
      item_r.channel_in_use   <= in_channel_in_use;
    end
    if (item_adv) res_r <= res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_arm_status     = res_r.arm_status;
  assign out_command_issued = res_r.command_issued;
  assign out_command_byte   = res_r.command_byte;
  assign out_value_armed    = res_r.value_armed;
  assign out_armed_percent  = res_r.armed_percent;
  assign out_goal_finished  = res_r.goal_finished;
  assign out_goal_ok        = res_r.goal_ok;
  assign out_route_missing  = res_r.route_missing;

  `PMWS_ASSERT_IMP(a_idle_no_settle, !st_r.goal_pending, st_r.settle_cnt == 4'd0)
  `PMWS_ASSERT_IMP(a_finish_dwell, out_valid_r && res_r.goal_finished,
                   res_r.command_issued && res_r.command_byte == pmws_pkg::KEY_DWELL)
  `PMWS_ASSERT_IMP(a_armed_submit, out_valid_r && res_r.value_armed,
                   res_r.command_byte == pmws_pkg::KEY_SUBMIT)
  `PMWS_ASSERT_IMP(a_ok_finished, out_valid_r && res_r.goal_ok, res_r.goal_finished)
  `PMWS_ASSERT_NXT(a_finish_clears, item_adv && res_nxt.goal_finished, !st_r.goal_pending)

endmodule
